// File: src/gqi_pkg.sv
// Shared types, constants and tables for the gyro quaternion integrator.
`default_nettype none
package gqi_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE = 1'd1;

  localparam int DEF_CORDIC_STEPS = 24;

  // Angle constants in 2^-30 rad
  localparam logic signed [36:0] TWO_PI_Q30  = 37'sd6746518852;
  localparam logic signed [36:0] PI_Q30      = 37'sd3373259426;
  localparam logic signed [36:0] HALF_PI_Q30 = 37'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_RATE, DP_MAC_SQ, DP_SQRT_M, DP_TAKE_M, DP_MAC_MDT,
    DP_TEST, DP_REDUCE, DP_FOLD, DP_CORDIC, DP_CSFIN, DP_DIV_AXIS,
    DP_AXIS_STORE, DP_MAC_HAM, DP_ROUND, DP_NORM_INIT, DP_NSHIFT, DP_ZERO,
    DP_MAC_MAG, DP_SQRT_N, DP_TAKE_N, DP_DIV_NORM, DP_NSTORE, DP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       clr;   // start a fresh accumulation
    logic [3:0] idx;   // element / product index
  } dp_cmd_t;

  typedef struct packed {
    logic over;        // angle above threshold
    logic reduced;     // angle below 2*pi
    logic cordic_last;
    logic zero;        // quaternion to normalize is all zero
    logic normed;      // largest magnitude in [2^29, 2^30)
    logic sqrt_busy;
    logic div_busy;
  } dp_status_t;

  // round(atan(2^-i) * 2^30)
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      default: v = 30'd1;
    endcase
    return v;
  endfunction

  // Hamilton product: term t of component comp is q[t] * d[comp ^ t],
  // negated where this returns 1.
  function automatic logic ham_neg(input logic [1:0] comp, input logic [1:0] t);
    logic n;
    case (comp)
      2'd0:    n = (t != 2'd0);
      2'd1:    n = (t == 2'd3);
      2'd2:    n = (t == 2'd1);
      default: n = (t == 2'd2);
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// File: src/gqi_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
`default_nettype none
module gqi_sqrt
  import gqi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             busy,
  output logic [31:0]      root
);
  localparam logic [5:0] STEPS = 6'd32;

  logic [63:0] rad_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [35:0] r4, trial;
  logic        ge;

  // one digit of the restoring recurrence
  assign r4    = {rem_r, rad_r[63:62]};
  assign trial = {2'b00, root_r, 2'b01};
  assign ge    = (r4 >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= STEPS;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      rad_r  <= {rad_r[61:0], 2'b00};
      rem_r  <= ge ? 34'(r4 - trial) : r4[33:0];
      root_r <= {root_r[30:0], ge};
      cnt_r  <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign root = root_r;
endmodule
`default_nettype wire

// File: src/gqi_div.sv
// Iterative restoring divider, 32 quotient bits, one bit per cycle.
`default_nettype none
module gqi_div
  import gqi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,  // upper half must be below divisor
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic [31:0]      quotient
);
  localparam logic [5:0] STEPS = 6'd32;

  logic [31:0] rem_r, lo_r, div_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [32:0] sh;
  logic        ge;

  assign sh = {rem_r, lo_r[31]};
  assign ge = (sh >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      rem_r  <= dividend[63:32];
      lo_r   <= dividend[31:0];
      div_r  <= divisor;
      cnt_r  <= STEPS;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      // quotient bits shift in as dividend bits shift out
      rem_r <= ge ? 32'(sh - {1'b0, div_r}) : sh[31:0];
      lo_r  <= {lo_r[30:0], ge};
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = lo_r;
endmodule
`default_nettype wire

// File: src/gqi_datapath.sv
// Datapath: state registers, shared multiplier, CORDIC, sqrt and divide units.
`default_nettype none
module gqi_datapath
  import gqi_pkg::*;
#(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_cmd_t            cmd,
  output dp_status_t              status,
  input  wire logic               cfg_average,
  input  wire logic [30:0]        cfg_min_angle,
  input  wire logic signed [15:0] in_rate_x,
  input  wire logic signed [15:0] in_rate_y,
  input  wire logic signed [15:0] in_rate_z,
  input  wire logic [23:0]        in_time_step,
  input  wire logic signed [31:0] in_set_w,
  input  wire logic signed [31:0] in_set_x,
  input  wire logic signed [31:0] in_set_y,
  input  wire logic signed [31:0] in_set_z,
  output logic signed [31:0]      out_w,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic                    out_rotated
);
  localparam int CI_W = $clog2(CORDIC_STEPS);

  // architectural state
  logic signed [31:0] q_r    [4];
  logic signed [15:0] prev_r [3];
  logic               have_prev_r;
  logic               rot_r;

  // working registers
  logic signed [16:0] s_r    [3];
  logic [23:0]        dt_r;
  logic signed [65:0] acc_r;
  logic [27:0]        m_r;
  logic signed [36:0] r_r;
  logic signed [33:0] x_r, y_r;
  logic [CI_W-1:0]    ci_r;
  logic               flip_r;
  logic signed [31:0] c_r, sn_r;
  logic signed [31:0] ax_r   [3];
  logic signed [35:0] a_r    [4];
  logic               neg_r  [4];
  logic [35:0]        mag_r  [4];
  logic [35:0]        mx_r;
  logic [31:0]        n_r;

  // output register
  logic signed [31:0] oq_r [4];
  logic               orot_r;

  logic signed [15:0] cur [3];
  logic signed [31:0] set_in [4];
  logic signed [31:0] d_vec [4];
  logic [16:0]        abs_s [3];
  logic [31:0]        abs_sn;
  logic signed [32:0] ma, mb;
  logic               mneg;
  logic signed [65:0] prod, rnd;
  logic [1:0]         comp, term;
  logic               use_avg;
  logic [35:0]        angle;
  logic signed [36:0] r_wrap;
  logic signed [33:0] dx, dy;
  logic signed [36:0] atan_v;
  logic [35:0]        amag [4];
  logic [35:0]        mx01, mx23;

  logic        sq_start, sq_busy;
  logic [63:0] sq_rad;
  logic [31:0] sq_root;
  logic        dv_start, dv_busy;
  logic [63:0] dv_dividend;
  logic [31:0] dv_divisor, dv_q;

  assign cur[0] = in_rate_x;
  assign cur[1] = in_rate_y;
  assign cur[2] = in_rate_z;
  assign set_in[0] = in_set_w;
  assign set_in[1] = in_set_x;
  assign set_in[2] = in_set_y;
  assign set_in[3] = in_set_z;
  assign d_vec[0] = c_r;
  assign d_vec[1] = ax_r[0];
  assign d_vec[2] = ax_r[1];
  assign d_vec[3] = ax_r[2];

  assign comp    = cmd.idx[3:2];
  assign term    = cmd.idx[1:0];
  assign use_avg = cfg_average && have_prev_r;
  assign abs_sn  = sn_r[31] ? 32'(-sn_r) : 32'(sn_r);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_s[i] = s_r[i][16] ? 17'(-s_r[i]) : 17'(s_r[i]);
    end
    for (int i = 0; i < 4; i++) begin
      amag[i] = a_r[i][35] ? 36'(-a_r[i]) : 36'(a_r[i]);
    end
    mx01 = (amag[0] > amag[1]) ? amag[0] : amag[1];
    mx23 = (amag[2] > amag[3]) ? amag[2] : amag[3];
  end

  // shared multiplier operand selection
  always_comb begin
    ma   = '0;
    mb   = '0;
    mneg = 1'b0;
    case (cmd.op)
      DP_MAC_SQ: begin
        ma = 33'(s_r[term]);
        mb = 33'(s_r[term]);
      end
      DP_MAC_MDT: begin
        ma = $signed({5'b0, m_r});
        mb = $signed({9'b0, dt_r});
      end
      DP_MAC_HAM: begin
        ma   = 33'(q_r[term]);
        mb   = 33'(d_vec[comp ^ term]);
        mneg = ham_neg(comp, term);
      end
      DP_MAC_MAG: begin
        ma = $signed({3'b0, mag_r[term][29:0]});
        mb = $signed({3'b0, mag_r[term][29:0]});
      end
      DP_DIV_AXIS: begin
        ma = $signed({1'b0, abs_sn});
        mb = $signed({16'b0, abs_s[term]});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = ma * mb;
  assign rnd  = acc_r + 66'sd536870912;

  // threshold test on |w|*dt
  assign angle = acc_r[51:16];

  // fold into [-pi/2, pi/2] after wrapping into [-pi, pi]
  assign r_wrap = (r_r > PI_Q30) ? (r_r - TWO_PI_Q30) : r_r;

  // CORDIC micro-rotation terms
  assign dx     = y_r >>> ci_r;
  assign dy     = x_r >>> ci_r;
  assign atan_v = $signed({7'b0, atan_q30(5'(ci_r))});

  // shared units
  assign sq_start = (cmd.op == DP_SQRT_M) || (cmd.op == DP_SQRT_N);
  assign sq_rad   = (cmd.op == DP_SQRT_M) ? {8'b0, acc_r[33:0], 22'b0}
                                          : {2'b0, acc_r[61:0]};
  assign dv_start = (cmd.op == DP_DIV_AXIS) || (cmd.op == DP_DIV_NORM);
  assign dv_dividend = (cmd.op == DP_DIV_AXIS) ? {prod[52:0], 11'b0}
                     : ({4'b0, mag_r[term][29:0], 30'b0} + {33'b0, n_r[31:1]});
  assign dv_divisor  = (cmd.op == DP_DIV_AXIS) ? {4'b0, m_r} : n_r;

  gqi_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_rad),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  gqi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (dv_dividend),
    .divisor  (dv_divisor),
    .busy     (dv_busy),
    .quotient (dv_q)
  );

  always_comb begin
    status.over        = (angle > {5'b0, cfg_min_angle});
    status.reduced     = (r_r < TWO_PI_Q30);
    status.cordic_last = (ci_r == CI_W'(CORDIC_STEPS - 1));
    status.zero        = (mx_r == '0);
    status.normed      = (mx_r[35:30] == '0) && mx_r[29];
    status.sqrt_busy   = sq_busy;
    status.div_busy    = dv_busy;
  end

  // operation execution
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r[0]      <= ONE_Q30;
      q_r[1]      <= '0;
      q_r[2]      <= '0;
      q_r[3]      <= '0;
      prev_r[0]   <= '0;
      prev_r[1]   <= '0;
      prev_r[2]   <= '0;
      have_prev_r <= 1'b0;
      rot_r       <= 1'b0;
    end else begin
      case (cmd.op)
        DP_LOAD: begin
          for (int i = 0; i < 4; i++) begin
            a_r[i] <= 36'(set_in[i]);
          end
          rot_r <= 1'b0;
        end
        DP_RATE: begin
          for (int i = 0; i < 3; i++) begin
            s_r[i]    <= use_avg ? (17'(cur[i]) + 17'(prev_r[i])) : (17'(cur[i]) <<< 1);
            prev_r[i] <= cur[i];
          end
          have_prev_r <= 1'b1;
          dt_r        <= in_time_step;
          rot_r       <= 1'b0;
        end
        DP_MAC_SQ, DP_MAC_MDT, DP_MAC_HAM, DP_MAC_MAG: begin
          acc_r <= (cmd.clr ? 66'sd0 : acc_r) + (mneg ? -prod : prod);
        end
        DP_TAKE_M: begin
          m_r <= sq_root[27:0];
        end
        DP_TEST: begin
          rot_r <= status.over;
          r_r   <= $signed({2'b0, acc_r[51:17]});
        end
        DP_REDUCE: begin
          r_r <= r_r - TWO_PI_Q30;
        end
        DP_FOLD: begin
          if (r_wrap > HALF_PI_Q30) begin
            r_r    <= r_wrap - PI_Q30;
            flip_r <= 1'b1;
          end else if (r_wrap < -HALF_PI_Q30) begin
            r_r    <= r_wrap + PI_Q30;
            flip_r <= 1'b1;
          end else begin
            r_r    <= r_wrap;
            flip_r <= 1'b0;
          end
          x_r  <= CORDIC_GAIN;
          y_r  <= '0;
          ci_r <= '0;
        end
        DP_CORDIC: begin
          if (!r_r[36]) begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            r_r <= r_r - atan_v;
          end else begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            r_r <= r_r + atan_v;
          end
          ci_r <= ci_r + CI_W'(1);
        end
        DP_CSFIN: begin
          c_r  <= flip_r ? 32'(-x_r) : 32'(x_r);
          sn_r <= flip_r ? 32'(-y_r) : 32'(y_r);
        end
        DP_AXIS_STORE: begin
          ax_r[term] <= (sn_r[31] ^ s_r[term][16]) ? -$signed(dv_q) : $signed(dv_q);
        end
        DP_ROUND: begin
          a_r[comp] <= 36'(rnd >>> 30);
        end
        DP_NORM_INIT: begin
          for (int i = 0; i < 4; i++) begin
            neg_r[i] <= a_r[i][35];
            mag_r[i] <= amag[i];
          end
          mx_r <= (mx01 > mx23) ? mx01 : mx23;
        end
        DP_NSHIFT: begin
          if (mx_r[35:30] != '0) begin
            for (int i = 0; i < 4; i++) begin
              mag_r[i] <= mag_r[i] >> 1;
            end
            mx_r <= mx_r >> 1;
          end else begin
            for (int i = 0; i < 4; i++) begin
              mag_r[i] <= mag_r[i] << 1;
            end
            mx_r <= mx_r << 1;
          end
        end
        DP_ZERO: begin
          for (int i = 0; i < 4; i++) begin
            q_r[i] <= '0;
          end
        end
        DP_TAKE_N: begin
          n_r <= (sq_root == '0) ? 32'd1 : sq_root;
        end
        DP_NSTORE: begin
          q_r[term] <= neg_r[term] ? -$signed(dv_q) : $signed(dv_q);
        end
        DP_OUT_LOAD: begin
          for (int i = 0; i < 4; i++) begin
            oq_r[i] <= q_r[i];
          end
          orot_r <= rot_r;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_w       = oq_r[0];
  assign out_x       = oq_r[1];
  assign out_y       = oq_r[2];
  assign out_z       = oq_r[3];
  assign out_rotated = orot_r;
endmodule
`default_nettype wire

// File: src/gqi_ctrl.sv
// Controller: sequences datapath operations for load and integrate items.
`default_nettype none
module gqi_ctrl
  import gqi_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_op,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  output dp_cmd_t         cmd,
  input  wire dp_status_t status
);
  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_SQRT_M, S_WAIT_M, S_MDT, S_TEST, S_REDUCE, S_CORDIC,
    S_CSFIN, S_AXDIV, S_AXWAIT, S_HAM, S_HROUND, S_NINIT, S_NSHIFT, S_NSQ,
    S_NSQRT, S_NWAIT, S_NDIV, S_NDWAIT, S_FINISH
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    cmd.op        = DP_NOP;
    cmd.clr       = 1'b0;
    cmd.idx       = k_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = in_op ? DP_LOAD : DP_RATE;
          state_nxt = in_op ? S_NINIT : S_SQ;
          k_nxt     = '0;
        end
      end
      S_SQ: begin
        cmd.op  = DP_MAC_SQ;
        cmd.clr = (k_r == 4'd0);
        if (k_r == 4'd2) begin
          k_nxt     = '0;
          state_nxt = S_SQRT_M;
        end else begin
          k_nxt = k_r + 4'd1;
        end
      end
      S_SQRT_M: begin
        cmd.op    = DP_SQRT_M;
        state_nxt = S_WAIT_M;
      end
      S_WAIT_M: begin
        if (!status.sqrt_busy) begin
          cmd.op    = DP_TAKE_M;
          state_nxt = S_MDT;
        end
      end
      S_MDT: begin
        cmd.op    = DP_MAC_MDT;
        cmd.clr   = 1'b1;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        cmd.op    = DP_TEST;
        state_nxt = status.over ? S_REDUCE : S_FINISH;
      end
      S_REDUCE: begin
        if (status.reduced) begin
          cmd.op    = DP_FOLD;
          state_nxt = S_CORDIC;
        end else begin
          cmd.op = DP_REDUCE;
        end
      end
      S_CORDIC: begin
        cmd.op = DP_CORDIC;
        if (status.cordic_last) begin
          state_nxt = S_CSFIN;
        end
      end
      S_CSFIN: begin
        cmd.op    = DP_CSFIN;
        k_nxt     = '0;
        state_nxt = S_AXDIV;
      end
      S_AXDIV: begin
        cmd.op    = DP_DIV_AXIS;
        state_nxt = S_AXWAIT;
      end
      S_AXWAIT: begin
        if (!status.div_busy) begin
          cmd.op = DP_AXIS_STORE;
          if (k_r == 4'd2) begin
            k_nxt     = '0;
            state_nxt = S_HAM;
          end else begin
            k_nxt     = k_r + 4'd1;
            state_nxt = S_AXDIV;
          end
        end
      end
      // four products per quaternion component, then round
      S_HAM: begin
        cmd.op  = DP_MAC_HAM;
        cmd.clr = (k_r[1:0] == 2'd0);
        if (k_r[1:0] == 2'd3) begin
          state_nxt = S_HROUND;
        end else begin
          k_nxt = k_r + 4'd1;
        end
      end
      S_HROUND: begin
        cmd.op = DP_ROUND;
        if (k_r == 4'd15) begin
          k_nxt     = '0;
          state_nxt = S_NINIT;
        end else begin
          k_nxt     = k_r + 4'd1;
          state_nxt = S_HAM;
        end
      end
      S_NINIT: begin
        cmd.op    = DP_NORM_INIT;
        state_nxt = S_NSHIFT;
      end
      S_NSHIFT: begin
        if (status.zero) begin
          cmd.op    = DP_ZERO;
          state_nxt = S_FINISH;
        end else if (status.normed) begin
          k_nxt     = '0;
          state_nxt = S_NSQ;
        end else begin
          cmd.op = DP_NSHIFT;
        end
      end
      S_NSQ: begin
        cmd.op  = DP_MAC_MAG;
        cmd.clr = (k_r == 4'd0);
        if (k_r == 4'd3) begin
          k_nxt     = '0;
          state_nxt = S_NSQRT;
        end else begin
          k_nxt = k_r + 4'd1;
        end
      end
      S_NSQRT: begin
        cmd.op    = DP_SQRT_N;
        state_nxt = S_NWAIT;
      end
      S_NWAIT: begin
        if (!status.sqrt_busy) begin
          cmd.op    = DP_TAKE_N;
          k_nxt     = '0;
          state_nxt = S_NDIV;
        end
      end
      S_NDIV: begin
        cmd.op    = DP_DIV_NORM;
        state_nxt = S_NDWAIT;
      end
      S_NDWAIT: begin
        if (!status.div_busy) begin
          cmd.op = DP_NSTORE;
          if (k_r == 4'd3) begin
            state_nxt = S_FINISH;
          end else begin
            k_nxt     = k_r + 4'd1;
            state_nxt = S_NDIV;
          end
        end
      end
      // hand the result to the output register once it is free
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op        = DP_OUT_LOAD;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

// File: src/gyro_quaternion_integrator.sv
// Top level of the gyro quaternion integrator.
// Keeps a unit orientation quaternion (Q2.30) and integrates gyro rate items
// (Q5.10 rad/s, time step in 2^-24 s) into it, or loads and normalizes a new
// quaternion; each item returns one result, the orientation after the item.
// One item is worked at a time by a controller and a datapath built around
// one shared 33x33 multiplier, an iterative square root unit and an iterative
// divider. An integrate item below the angle threshold leaves the quaternion
// as it is; one that rotates does up to five reductions by 2*pi, the CORDIC,
// the Hamilton product and a normalize; a load item is normalized unless it
// is all zero, which loads a zero quaternion. The output register lets a new
// item be taken while a result waits.
`default_nettype none
module gyro_quaternion_integrator
  import gqi_pkg::*;
#(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_op,
  input  wire logic signed [15:0]   in_rate_x,
  input  wire logic signed [15:0]   in_rate_y,
  input  wire logic signed [15:0]   in_rate_z,
  input  wire logic [23:0]          in_time_step,
  input  wire logic signed [31:0]   in_set_w,
  input  wire logic signed [31:0]   in_set_x,
  input  wire logic signed [31:0]   in_set_y,
  input  wire logic signed [31:0]   in_set_z,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [31:0]        out_w,
  output logic signed [31:0]        out_x,
  output logic signed [31:0]        out_y,
  output logic signed [31:0]        out_z,
  output logic                      out_rotated,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);
  logic        avg_r;
  logic [30:0] min_angle_r;
  dp_cmd_t     cmd;
  dp_status_t  status;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r       <= 1'b1;
      min_angle_r <= 31'd1074;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_AVERAGE:   avg_r       <= cfg_data[0];
        CFG_MIN_ANGLE: min_angle_r <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  gqi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  gqi_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .cfg_average   (avg_r),
    .cfg_min_angle (min_angle_r),
    .in_rate_x     (in_rate_x),
    .in_rate_y     (in_rate_y),
    .in_rate_z     (in_rate_z),
    .in_time_step  (in_time_step),
    .in_set_w      (in_set_w),
    .in_set_x      (in_set_x),
    .in_set_y      (in_set_y),
    .in_set_z      (in_set_z),
    .out_w         (out_w),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_rotated   (out_rotated)
  );
endmodule
`default_nettype wire

// File: src/gqi_checker.sv
// Port-level checks for the gyro quaternion integrator, bound to the top.
`default_nettype none
module gqi_checker
  import gqi_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 in_op,
  input wire logic signed [15:0]   in_rate_x,
  input wire logic signed [15:0]   in_rate_y,
  input wire logic signed [15:0]   in_rate_z,
  input wire logic [23:0]          in_time_step,
  input wire logic signed [31:0]   in_set_w,
  input wire logic signed [31:0]   in_set_x,
  input wire logic signed [31:0]   in_set_y,
  input wire logic signed [31:0]   in_set_z,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic signed [31:0]   out_w,
  input wire logic signed [31:0]   out_x,
  input wire logic signed [31:0]   out_y,
  input wire logic signed [31:0]   out_z,
  input wire logic                 out_rotated,
  input wire logic                 cfg_valid,
  input wire logic                 cfg_ready,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [31:0]          cfg_data
);
  // a result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_w) && $stable(out_x) &&
      $stable(out_y) && $stable(out_z) && $stable(out_rotated))
    else $error("stalled result changed");

  // one item at a time: an accepted item blocks the input next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled while an item is in work");

  // no result straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");
endmodule

bind gyro_quaternion_integrator gqi_checker u_gqi_checker (.*);
`default_nettype wire
